>>> sv/lxfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxfd_pkg
// Shared types and constants of the length/XOR frame deframer.
// ----------------------------------------------------------------------------
package lxfd_pkg;

  // Frame delimiters
  localparam logic [7:0] START_BYTE = 8'h5C;
  localparam logic [7:0] END_BYTE   = 8'h5D;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_XOR_CHECK_EN = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_BODY_LEN = 2'd1;

  localparam logic [LenW-1:0] MAX_BODY_LEN_RST = 16'd2048;

  // Result codes
  typedef enum logic [2:0] {
    KIND_BODY     = 3'd0,
    KIND_COMMIT   = 3'd1,
    KIND_BAD_END  = 3'd2,
    KIND_BAD_XOR  = 3'd3,
    KIND_TOO_LONG = 3'd4
  } kind_e;

  // Parser phase, one-hot
  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_LEN_LO = 6'b000010,
    PH_LEN_HI = 6'b000100,
    PH_BODY   = 6'b001000,
    PH_CHECK  = 6'b010000,
    PH_END    = 6'b100000
  } phase_e;

  typedef struct packed {
    logic            xor_check_en;
    logic [LenW-1:0] max_body_len;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] body_byte;
    logic [LenW-1:0]  byte_index;
    logic [LenW-1:0]  frame_length;
  } result_t;

endpackage

>>> sv/lxfd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxfd_cfg_regs
// Configuration register file: index decode and the two control registers.
// ----------------------------------------------------------------------------
module lxfd_cfg_regs import lxfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [LenW-1:0]    cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode one write transfer; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_XOR_CHECK_EN: cfg_d.xor_check_en = cfg_data_i[0];
        CFG_MAX_BODY_LEN: cfg_d.max_body_len = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.xor_check_en <= 1'b1;
      cfg_q.max_body_len <= MAX_BODY_LEN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/lxfd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxfd_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module lxfd_in_stage import lxfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic             take_i,     // parser consumes the held byte
  output logic             valid_o,
  output logic [ByteW-1:0] byte_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             load;

  // Room when empty or when the held byte leaves this cycle
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

>>> sv/lxfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxfd_parser
// Frame state machine with length, byte count and running XOR; one byte
// per step, at most one result per byte.
// ----------------------------------------------------------------------------
module lxfd_parser import lxfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  input  cfg_t             cfg_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  phase_e           phase_q, phase_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  seen_q, seen_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [LenW-1:0]  len_new;
  logic [LenW-1:0]  seen_inc;

  assign len_new  = {byte_i, len_q[ByteW-1:0]};
  assign seen_inc = seen_q + LenW'(1);

  // Next state and result for the byte in the input register
  always_comb begin
    phase_d            = phase_q;
    len_d              = len_q;
    seen_d             = seen_q;
    xor_d              = xor_q;
    res_valid_o        = 1'b0;
    res_o.kind         = KIND_BODY;
    res_o.body_byte    = '0;
    res_o.byte_index   = '0;
    res_o.frame_length = len_q;
    if (step_i) begin
      unique case (phase_q)
        PH_LEN_LO: begin
          len_d   = {{(LenW-ByteW){1'b0}}, byte_i};
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_d              = len_new;
          res_o.frame_length = len_new;
          if (len_new > cfg_i.max_body_len) begin
            phase_d     = PH_HUNT;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_TOO_LONG;
          end else if (len_new == '0) begin
            phase_d = PH_CHECK;   // empty body, checksum is zero
          end else begin
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          xor_d            = xor_q ^ byte_i;
          seen_d           = seen_inc;
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_BODY;
          res_o.body_byte  = byte_i;
          res_o.byte_index = seen_q;
          if (seen_inc >= len_q) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          // checksum byte is always consumed
          if (cfg_i.xor_check_en && (byte_i != xor_q)) begin
            phase_d     = PH_HUNT;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_BAD_XOR;
          end else begin
            phase_d = PH_END;
          end
        end
        PH_END: begin
          phase_d     = PH_HUNT;
          res_valid_o = 1'b1;
          res_o.kind  = (byte_i == END_BYTE) ? KIND_COMMIT : KIND_BAD_END;
        end
        default: begin
          // hunting for the start byte
          phase_d = PH_HUNT;
          if (byte_i == START_BYTE) begin
            len_d   = '0;
            seen_d  = '0;
            xor_d   = '0;
            phase_d = PH_LEN_LO;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      seen_q  <= '0;
      xor_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      xor_q   <= xor_d;
    end
  end

`ifndef NO_ASSERTIONS
  // Body count never reaches the declared length while still in the body
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> seen_q < len_q)
    else $error("lxfd_parser: byte count at or past length in body");

  // A start byte while hunting opens a clean frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_HUNT && byte_i == START_BYTE
    |=> phase_q == PH_LEN_LO && seen_q == '0 && xor_q == '0)
    else $error("lxfd_parser: frame start did not clear state");

  // Checksum byte leads to the end byte or back to hunting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_CHECK |=> phase_q == PH_END || phase_q == PH_HUNT)
    else $error("lxfd_parser: bad phase after checksum byte");
`endif

endmodule

>>> sv/lxfd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxfd_out_reg
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module lxfd_out_reg import lxfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,     // can take a result this cycle
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  // Never overwrite a result that has not been transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && valid_q |-> out_ready_i)
    else $error("lxfd_out_reg: result overwritten before transfer");
`endif

endmodule

>>> sv/length_xor_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_xor_frame_deframer
// Byte-serial parser for 0x5C / length / body / XOR / 0x5D frames.
//
//   channel | handshake                 | payload
//   --------+---------------------------+------------------------------------
//   in      | in_valid_i, in_ready_o    | rx_byte_i
//   out     | out_valid_o, out_ready_i  | kind_o, body_byte_o, byte_index_o, frame_length_o
//   cfg     | cfg_valid_i, cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One byte per cycle while the result register is not stalled. A byte is held
// in the input register, the state machine steps on it, and any result is
// registered in the result register, which drives out_valid_o.
// Reset clears the state machine and loads the register defaults.
// A stalled result register holds the parser; the input register still
// takes one more byte, then in_ready_o drops. Config writes are registered.
// ----------------------------------------------------------------------------
module length_xor_frame_deframer import lxfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input bytes
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ByteW-1:0]   rx_byte_i,
  // results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         kind_o,
  output logic [ByteW-1:0]   body_byte_o,
  output logic [LenW-1:0]    byte_index_o,
  output logic [LenW-1:0]    frame_length_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [LenW-1:0]    cfg_data_i
);

  cfg_t             cfg;
  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             out_free;
  logic             step;
  logic             res_valid;
  result_t          res, res_out;

  assign cfg_ready_o = 1'b1;

  lxfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Parser steps whenever a byte is held and the result register has room
  assign step = s1_valid && out_free;

  lxfd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (step),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  lxfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (s1_byte),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lxfd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign kind_o         = res_out.kind;
  assign body_byte_o    = res_out.body_byte;
  assign byte_index_o   = res_out.byte_index;
  assign frame_length_o = res_out.frame_length;

`ifndef NO_ASSERTIONS
  // Input side only stalls behind a stalled, full result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("length_xor_frame_deframer: input stalled without cause");

  // A held byte is stepped on whenever the output side is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && (!out_valid_o || out_ready_i) |-> step)
    else $error("length_xor_frame_deframer: parser idle with work pending");
`endif

endmodule
